FILE: hw/rtl/srng_pkg.sv
// Shared constants and item types for the shuffled minimal standard generator.
// No dependencies.
package srng_pkg;

    localparam int VAL_W           = 31;
    localparam int PROD_W          = 46;
    localparam int DEF_TABLE_SIZE  = 32;
    localparam int WARMUP_EXTRA    = 8;

    localparam logic [14:0]      LCG_MULT = 15'd16807;
    localparam logic [VAL_W-1:0] LCG_MOD  = 31'h7FFF_FFFF;

    localparam logic CMD_DRAW   = 1'b0;
    localparam logic CMD_RESEED = 1'b1;

    typedef struct packed {
        logic             command;
        logic [VAL_W-1:0] seed;
    } t_req;

    typedef struct packed {
        logic [VAL_W-1:0] value;
    } t_rsp;

endpackage

FILE: hw/rtl/srng_chan_if.sv
// Valid/ready channel carrying one item of type T.
// Used with the item types of srng_pkg.
interface srng_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/srng_lcg.sv
// Park-Miller step: registered 31x15 multiply, then Mersenne fold mod 2^31-1.
// Depends on srng_pkg.
module srng_lcg
    import srng_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [VAL_W-1:0] i_g,
    output logic [VAL_W-1:0] o_next
);

    logic [PROD_W-1:0] r_prod;
    logic [VAL_W:0]    w_sum;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= PROD_W'(i_g) * PROD_W'(LCG_MULT);
        end
    end

    // 2^31 == 1 mod (2^31-1): add high part to low part, one correction
    always_comb begin
        w_sum = {1'b0, r_prod[VAL_W-1:0]} + (VAL_W+1)'(r_prod[PROD_W-1:VAL_W]);
        if (w_sum >= {1'b0, LCG_MOD}) begin
            o_next = VAL_W'(w_sum - {1'b0, LCG_MOD});
        end else begin
            o_next = w_sum[VAL_W-1:0];
        end
    end

endmodule

FILE: hw/rtl/srng_table.sv
// Shuffle table: one write port, one read port, registered read data.
// Depends on srng_pkg.
module srng_table
    import srng_pkg::*;
#(
    parameter int DEPTH = DEF_TABLE_SIZE,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [VAL_W-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [VAL_W-1:0] o_rdata
);

    logic [VAL_W-1:0] r_mem [DEPTH];
    logic [VAL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/shuffled_minimal_standard_rng_unit.sv
// Shuffled minimal standard generator: Park-Miller step plus Bays-Durham table.
// Depends on srng_pkg, srng_chan_if, srng_lcg and srng_table.
//
// Usage:
//   i_req carries command and seed; o_rsp carries one value per request item.
//   command 0 draws; command 1 reseeds from seed (0 or 2^31-1 taken as 1) and
//   then draws. A draw on a never-seeded block seeds with 1 first.
//   A draw does the table read and the registered multiply first, then the
//   fold and write-back. A reseed runs TABLE_SIZE+8 warm-up steps, each
//   passing the shared multiplier and fold unit through ST_SMUL and ST_SFOLD,
//   the last TABLE_SIZE of them filling the table, before its draw.
//   One item is in flight at a time; i_req.ready is high whenever no item is
//   being worked on, also while a result waits in the output register.
//   If the receiver stalls, the result holds in the output register and a
//   following item stops at its write-back until the register frees.
//   Reset clears r_gen and r_last (zero marks unseeded); table needs no reset.
module shuffled_minimal_standard_rng_unit
    import srng_pkg::*;
#(
    parameter int TABLE_SIZE = DEF_TABLE_SIZE
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    srng_chan_if.sink   i_req,
    srng_chan_if.source o_rsp
);

    localparam int AW      = $clog2(TABLE_SIZE);
    localparam int CNT_W   = $clog2(TABLE_SIZE + WARMUP_EXTRA);
    localparam int SlotDiv = 1 + (2147483646 / TABLE_SIZE);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SMUL  = 3'd1;
    localparam logic [2:0] ST_SFOLD = 3'd2;
    localparam logic [2:0] ST_DRD   = 3'd3;
    localparam logic [2:0] ST_WB    = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [VAL_W-1:0] r_gen, n_gen;
    logic [VAL_W-1:0] r_last, n_last;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [AW-1:0]    r_wslot, n_wslot;
    logic             r_out_valid, n_out_valid;
    logic [VAL_W-1:0] r_out, n_out;

    logic             w_accept;
    logic             w_start_draw;
    logic             w_lcg_en;
    logic [VAL_W-1:0] w_lcg_next;
    logic [AW-1:0]    w_slot;
    logic [TABLE_SIZE:0] w_ge;
    logic [VAL_W-1:0] w_seed;
    logic             w_wb_go;
    logic             w_tbl_we;
    logic [AW-1:0]    w_tbl_waddr;
    logic [VAL_W-1:0] w_tbl_rdata;

    // slot = last / SlotDiv, clamp implied by the top threshold
    always_comb begin
        w_ge             = '0;
        w_ge[0]          = 1'b1;
        w_slot           = '0;
        for (int k = 1; k < TABLE_SIZE; k++) begin
            w_ge[k] = ({1'b0, r_last} >= 32'(k * SlotDiv));
        end
        for (int k = 0; k < TABLE_SIZE; k++) begin
            if (w_ge[k] && !w_ge[k+1]) begin
                w_slot = w_slot | AW'(k);
            end
        end
    end

    assign w_accept     = i_req.valid && i_req.ready;
    assign w_seed       = (i_req.data.seed == '0 || i_req.data.seed == LCG_MOD)
                          ? VAL_W'(1) : i_req.data.seed;
    assign w_start_draw = (r_state == ST_DRD) ||
                          (w_accept && i_req.data.command == CMD_DRAW && r_last != '0);
    assign w_lcg_en     = w_start_draw || (r_state == ST_SMUL);
    assign w_wb_go      = (r_state == ST_WB) && (!r_out_valid || o_rsp.ready);
    assign w_tbl_we     = w_wb_go ||
                          ((r_state == ST_SFOLD) && (r_cnt < CNT_W'(TABLE_SIZE)));
    assign w_tbl_waddr  = (r_state == ST_WB) ? r_wslot : r_cnt[AW-1:0];

    srng_lcg u_lcg (
        .i_clk  (i_clk),
        .i_en   (w_lcg_en),
        .i_g    (r_gen),
        .o_next (w_lcg_next)
    );

    srng_table #(
        .DEPTH (TABLE_SIZE),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_tbl_we),
        .i_waddr (w_tbl_waddr),
        .i_wdata (w_lcg_next),
        .i_re    (w_start_draw),
        .i_raddr (w_slot),
        .o_rdata (w_tbl_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_gen       = r_gen;
        n_last      = r_last;
        n_cnt       = r_cnt;
        n_wslot     = r_wslot;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_rsp.ready;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (w_start_draw) begin
                        n_wslot = w_slot;
                        n_state = ST_WB;
                    end else begin
                        n_gen   = (i_req.data.command == CMD_RESEED) ? w_seed : VAL_W'(1);
                        n_cnt   = CNT_W'(TABLE_SIZE + WARMUP_EXTRA - 1);
                        n_state = ST_SMUL;
                    end
                end
            end
            ST_SMUL: begin
                n_state = ST_SFOLD;
            end
            ST_SFOLD: begin
                n_gen = w_lcg_next;
                if (r_cnt == '0) begin
                    n_last  = w_lcg_next;
                    n_state = ST_DRD;
                end else begin
                    n_cnt   = r_cnt - CNT_W'(1);
                    n_state = ST_SMUL;
                end
            end
            ST_DRD: begin
                n_wslot = w_slot;
                n_state = ST_WB;
            end
            ST_WB: begin
                if (w_wb_go) begin
                    n_gen       = w_lcg_next;
                    n_last      = w_tbl_rdata;
                    n_out       = w_tbl_rdata;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_gen       <= '0;
            r_last      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_gen       <= n_gen;
            r_last      <= n_last;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wslot <= n_wslot;
        r_out   <= n_out;
    end

    assign i_req.ready      = (r_state == ST_IDLE);
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.data.value = r_out;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state != ST_IDLE)
        else $error("accepted item did not start work");

    a_gen_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> r_gen != '0)
        else $error("generator zero while working");

    a_we_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tbl_we |-> (r_state == ST_SFOLD || r_state == ST_WB))
        else $error("table write outside fill or write-back");

    a_result_from_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ST_WB)
        else $error("result appeared without write-back");

    a_value_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out != '0)
        else $error("zero value delivered");

endmodule
